/* sv/masked_byte_pattern_scan_assert.svh */
// assertion macros shared by the scan block
`ifndef MASKED_BYTE_PATTERN_SCAN_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SCAN_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MBPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define MBPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/mbps_pkg.sv */
// shared types and constants of the masked byte pattern scan
package mbps_pkg;

	localparam int DATA_W          = 8;
	localparam int ADDR_W          = 32;
	localparam int POS_W           = 33;
	localparam int LEN_W           = 5;
	localparam int PAT_BYTES       = 24;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 64;
	localparam int MAX_PATTERN_DEF = 24;

	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_MID  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CARE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE     = 3'd6;

	typedef logic [PAT_BYTES-1:0][DATA_W-1:0] pattern_t;

	typedef struct packed {
		pattern_t              pattern;
		logic [PAT_BYTES-1:0]  care;
		logic [LEN_W-1:0]      length;
		logic [ADDR_W-1:0]     base;
		logic [ADDR_W-1:0]     size;
	} cfg_t;

	// window update control from the scan sequencing to the window
	typedef struct packed {
		logic              restart;
		logic              zero;
		logic              load;
		logic [DATA_W-1:0] data_byte;
	} win_ctrl_t;

endpackage

/* sv/mbps_if.sv */
// channel interfaces: byte stream in, result out, configuration write
interface mbps_scan_if;
	import mbps_pkg::*;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_byte;
	logic              first_byte;
	logic              last_byte;
	modport source (output valid, data_byte, first_byte, last_byte, input ready);
	modport sink (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface mbps_result_if;
	import mbps_pkg::*;
	logic              valid;
	logic              ready;
	logic              found;
	logic [ADDR_W-1:0] match_address;
	modport source (output valid, found, match_address, input ready);
	modport sink (input valid, found, match_address, output ready);
endinterface

interface mbps_cfg_if;
	import mbps_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/mbps_cfg_regs.sv */
// configuration register file
module mbps_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	mbps_cfg_if.sink      cfg,
	output mbps_pkg::cfg_t regs
);
	import mbps_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '{pattern: '0, care: '0, length: LEN_W'(1), base: '0, size: '0};
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PAT_LOW:  regs_q.pattern[7:0]   <= cfg.data;
				REG_PAT_MID:  regs_q.pattern[15:8]  <= cfg.data;
				REG_PAT_HIGH: regs_q.pattern[23:16] <= cfg.data;
				REG_CARE:     regs_q.care   <= cfg.data[PAT_BYTES-1:0];
				REG_LENGTH:   regs_q.length <= cfg.data[LEN_W-1:0];
				REG_BASE:     regs_q.base   <= cfg.data[ADDR_W-1:0];
				REG_SIZE:     regs_q.size   <= cfg.data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end
endmodule

/* sv/mbps_window.sv */
// byte window shift register and masked pattern compare
module mbps_window #(
	parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mbps_pkg::win_ctrl_t                ctrl,
	input  mbps_pkg::pattern_t                 pattern,
	input  logic [mbps_pkg::PAT_BYTES-1:0]     care,
	input  logic [$clog2(MAX_PATTERN+1)-1:0]   n_used,
	output logic                               match
);
	import mbps_pkg::*;

	localparam int NW  = $clog2(MAX_PATTERN + 1);
	localparam int WIW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [MAX_PATTERN-1:0][DATA_W-1:0] win_q;
	logic [MAX_PATTERN-1:0][DATA_W-1:0] win_base;
	logic [MAX_PATTERN-1:0][DATA_W-1:0] win_cand;
	logic [MAX_PATTERN-1:0]             miss;

	// window as it stands after this byte, entry 0 newest
	always_comb begin
		win_base    = ctrl.restart ? '0 : win_q;
		win_cand[0] = ctrl.data_byte;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			win_cand[k] = win_base[k-1];
		end
	end

	// pattern byte j lines up with window entry n-1-j
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cmp
		logic [WIW-1:0] idx;
		assign idx = WIW'(n_used - NW'(j + 1));
		if (j < PAT_BYTES) begin : g_pat
			assign miss[j] = (NW'(j) < n_used) && care[j] && (win_cand[idx] != pattern[j]);
		end else begin : g_wild
			assign miss[j] = 1'b0;
		end
	end

	assign match = ~|miss;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctrl.load) begin
			win_q <= win_cand;
		end else if (ctrl.zero) begin
			win_q <= '0;
		end
	end
endmodule

/* sv/masked_byte_pattern_scan.sv */
// Masked byte pattern scan: takes one byte per transaction on the scan channel and
// reports the address of the first position where the last pattern_length bytes match
// the configured pattern on every care byte, for start offsets below region_size; a
// transaction with last_byte set and no match yields found = 0 with address 0. A
// transaction with first_byte set opens a new scan; after one result, bytes are taken
// and dropped until the next first_byte. One byte is taken every cycle while results
// are taken as they come; a result is valid once its byte has moved from the input
// register through one compare stage into the result register, and a result held
// by the sink stalls the byte behind it. The compare over up to MAX_PATTERN window
// bytes and the offset subtract and range check share that single stage.
// Configuration writes take effect at once and must happen while no byte is in flight.
module masked_byte_pattern_scan #(
	parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mbps_scan_if.sink     scan,
	mbps_result_if.source result,
	mbps_cfg_if.sink      cfg
);
	import mbps_pkg::*;

	`include "masked_byte_pattern_scan_assert.svh"

	localparam int NW = $clog2(MAX_PATTERN + 1);

	cfg_t      regs;
	win_ctrl_t win_ctrl;
	logic      win_match;

	// input register
	logic              valid_s1;
	logic [DATA_W-1:0] byte_s1;
	logic              first_s1;
	logic              last_s1;

	// result register
	logic              valid_s2;
	logic              found_s2;
	logic [ADDR_W-1:0] addr_s2;

	// scan state
	logic [POS_W-1:0] pos_q;
	logic             reported_q;

	logic             adv;
	logic             rep_eff;
	logic             work;
	logic [NW-1:0]    n_used;
	logic [POS_W-1:0] pos_base;
	logic [POS_W-1:0] pos_next;
	logic [POS_W-1:0] offset;
	logic             cand;
	logic             hit;
	logic             emit;

	mbps_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// effective pattern length: zero acts as one, clamp at window depth
	always_comb begin
		if (regs.length == '0) begin
			n_used = NW'(1);
		end else if (int'(regs.length) > MAX_PATTERN) begin
			n_used = NW'(MAX_PATTERN);
		end else begin
			n_used = NW'(regs.length);
		end
	end

	// stage 1 moves on when the result register is free or being drained
	assign adv        = valid_s1 && (!valid_s2 || result.ready);
	assign scan.ready = !valid_s1 || adv;

	// a new scan clears the report flag before this byte is looked at
	assign rep_eff  = !first_s1 && reported_q;
	assign work     = !rep_eff;
	assign pos_base = first_s1 ? '0 : pos_q;
	assign pos_next = (pos_base == POS_MAX) ? pos_base : pos_base + POS_W'(1);

	// start offset of the window and its range check
	assign offset = pos_next - POS_W'(n_used);
	assign cand   = (pos_next >= POS_W'(n_used)) && (offset < POS_W'(regs.size));
	assign hit    = work && cand && win_match;
	assign emit   = work && (hit || last_s1);

	assign win_ctrl.restart   = first_s1;
	assign win_ctrl.zero      = adv && first_s1;
	assign win_ctrl.load      = adv && work;
	assign win_ctrl.data_byte = byte_s1;

	mbps_window #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (win_ctrl),
		.pattern (regs.pattern),
		.care    (regs.care),
		.n_used  (n_used),
		.match   (win_match)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.ready) begin
			valid_s1 <= scan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.valid && scan.ready) begin
			byte_s1  <= scan.data_byte;
			first_s1 <= scan.first_byte;
			last_s1  <= scan.last_byte;
		end
	end

	// scan position and report flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			reported_q <= 1'b0;
		end else if (adv) begin
			reported_q <= rep_eff || emit;
			if (work) begin
				pos_q <= pos_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv && emit) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			found_s2 <= hit;
			addr_s2  <= hit ? regs.base + offset[ADDR_W-1:0] : '0;
		end
	end

	assign result.valid         = valid_s2;
	assign result.found         = found_s2;
	assign result.match_address = addr_s2;

	// not-found results carry a zero address
	`MBPS_ASSERT_NOW(a_notfound_zero, valid_s2 && !found_s2, addr_s2 == '0, "not-found address nonzero")
	// a held result never gets overwritten by stage 1
	`MBPS_ASSERT_NOW(a_no_overrun, valid_s2 && !result.ready, !adv, "result overwritten while stalled")
	// every emitted result closes the scan
	`MBPS_ASSERT_NEXT(a_report_sets, adv && emit, reported_q, "report flag not set after result")
	// a closed scan stays silent until a new first byte
	`MBPS_ASSERT_NOW(a_silent_after, adv && reported_q && !first_s1, !emit, "result after scan ended")

endmodule

/* verif/tb.sv */
// testbench of the masked byte pattern scan: self-checking stream, result and config traffic
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mbps_pkg::*;

	// index past the last register, writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// one byte of the scanned stream as it goes out on the scan channel
	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              first;
		logic              last;
	} stream_byte_t;

	// one scan outcome as it should appear on the result channel
	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] addr;
	} scan_result_t;

	logic clk;
	logic arst_n;

	mbps_scan_if   scan_ch ();
	mbps_result_if result_ch ();
	mbps_cfg_if    cfg_ch ();

	masked_byte_pattern_scan uut (
		.clk    (clk),
		.arst_n (arst_n),
		.scan   (scan_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// bytes waiting to go out, and the scan outcomes still owed by the block
	stream_byte_t pending_bytes [$];
	scan_result_t expected_results [$];

	// shadow copy of the registers and of the scan state
	cfg_t             scan_cfg;
	pattern_t         scan_window;
	logic [POS_W-1:0] bytes_seen;
	logic             scan_done;

	int unsigned queued_count;
	int unsigned accepted_count;
	int          mismatch_count;
	int          random_bytes;
	int          phase_no;
	int          src_idle_pct;
	int          snk_idle_pct;

	// clock, reset asserted from the start, every block input known at time zero
	initial begin
		clk                 = 1'b0;
		arst_n              = 1'b0;
		scan_ch.valid       = 1'b0;
		scan_ch.data_byte   = '0;
		scan_ch.first_byte  = 1'b0;
		scan_ch.last_byte   = 1'b0;
		result_ch.ready     = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = REG_PAT_LOW;
		cfg_ch.data         = '0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs on a handshake
	initial begin
		#2_000_000;
		$display("masked_byte_pattern_scan: mismatch");
		$finish;
	end

	// pattern length actually in use: zero acts as one, above the window acts as full window
	function automatic int pattern_span(logic [LEN_W-1:0] len);
		if (len == 0)
			return 1;
		if (len > MAX_PATTERN_DEF)
			return MAX_PATTERN_DEF;
		return int'(len);
	endfunction

	// advance the shadow scan state by one accepted byte, queue the outcome it causes
	task automatic predict_scan_byte(stream_byte_t item);
		int               n;
		int               j;
		logic [POS_W-1:0] start;
		bit               hit;
		scan_result_t     outcome;
		n = pattern_span(scan_cfg.length);
		if (item.first) begin
			scan_window = '0;
			bytes_seen  = '0;
			scan_done   = 1'b0;
		end
		// scan already ended: bytes are dropped until the next first byte
		if (scan_done)
			return;
		scan_window = {scan_window[PAT_BYTES-2:0], item.data};
		if (bytes_seen != POS_MAX)
			bytes_seen++;
		if (bytes_seen >= POS_W'(n)) begin
			start = bytes_seen - POS_W'(n);
			if (start < POS_W'(scan_cfg.size)) begin
				hit = 1'b1;
				// pattern byte j sits n-1-j places behind the newest byte
				for (j = 0; j < n; j++)
					if (scan_cfg.care[j] && scan_window[n-1-j] !== scan_cfg.pattern[j])
						hit = 1'b0;
				if (hit) begin
					outcome.found = 1'b1;
					outcome.addr  = scan_cfg.base + start[ADDR_W-1:0];
					expected_results.push_back(outcome);
					scan_done = 1'b1;
					return;
				end
			end
		end
		// a match on the last byte wins, otherwise the scan ends as not found
		if (item.last) begin
			outcome.found = 1'b0;
			outcome.addr  = '0;
			expected_results.push_back(outcome);
			scan_done = 1'b1;
		end
	endtask

	// stream driver: valid is held until ready, a new byte goes out only on a free slot
	always @(posedge clk or negedge arst_n) begin : stream_driver
		stream_byte_t next_byte;
		if (!arst_n) begin
			scan_ch.valid      <= 1'b0;
			scan_ch.data_byte  <= '0;
			scan_ch.first_byte <= 1'b0;
			scan_ch.last_byte  <= 1'b0;
			scan_window        = '0;
			bytes_seen         = '0;
			scan_done          = 1'b0;
			scan_cfg.pattern   = '0;
			scan_cfg.care      = '0;
			scan_cfg.length    = LEN_W'(1);
			scan_cfg.base      = '0;
			scan_cfg.size      = '0;
		end else begin
			// transaction on the scan channel: predict and count in one step
			if (scan_ch.valid && scan_ch.ready) begin
				predict_scan_byte({scan_ch.data_byte, scan_ch.first_byte, scan_ch.last_byte});
				accepted_count++;
			end
			if (!scan_ch.valid || scan_ch.ready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					next_byte = pending_bytes.pop_front();
					scan_ch.valid      <= 1'b1;
					scan_ch.data_byte  <= next_byte.data;
					scan_ch.first_byte <= next_byte.first;
					scan_ch.last_byte  <= next_byte.last;
				end else begin
					scan_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compare every result transaction with the oldest outcome owed
	always @(posedge clk or negedge arst_n) begin : result_monitor
		scan_result_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: found=%0b addr=%h",
							result_ch.found, result_ch.match_address);
				end else begin
					want = expected_results.pop_front();
					if (result_ch.found !== want.found || result_ch.match_address !== want.addr) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("bad result: expected found=%0b addr=%h, got found=%0b addr=%h",
								want.found, want.addr, result_ch.found, result_ch.match_address);
					end
				end
			end
			result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	task automatic push_byte(logic [DATA_W-1:0] data, logic first, logic last);
		pending_bytes.push_back({data, first, last});
		queued_count++;
	endtask

	// hold the stream until every byte is taken and every outcome is back, then let
	// the two-stage pipe drain of bytes that carry no result
	task automatic wait_idle();
		while (accepted_count != queued_count || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one write transaction on the config channel, shadow register updated on the handshake
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		forever begin
			@(posedge clk);
			if (cfg_ch.ready)
				break;
		end
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_PAT_LOW:  scan_cfg.pattern[7:0]   = value;
			REG_PAT_MID:  scan_cfg.pattern[15:8]  = value;
			REG_PAT_HIGH: scan_cfg.pattern[23:16] = value;
			REG_CARE:     scan_cfg.care           = value[PAT_BYTES-1:0];
			REG_LENGTH:   scan_cfg.length         = value[LEN_W-1:0];
			REG_BASE:     scan_cfg.base           = value[ADDR_W-1:0];
			REG_SIZE:     scan_cfg.size           = value[ADDR_W-1:0];
			default: ;
		endcase
	endtask

	// write every register; with noise set, unused upper data bits carry random junk
	task automatic configure(pattern_t pat, logic [PAT_BYTES-1:0] care, logic [LEN_W-1:0] len,
		logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] size, bit noise);
		logic [CFG_DATA_W-1:0] junk;
		junk = noise ? {$urandom, $urandom} : '0;
		cfg_write(REG_PAT_LOW, pat[7:0]);
		cfg_write(REG_PAT_MID, pat[15:8]);
		cfg_write(REG_PAT_HIGH, pat[23:16]);
		cfg_write(REG_CARE, {junk[CFG_DATA_W-1:PAT_BYTES], care});
		cfg_write(REG_LENGTH, {junk[CFG_DATA_W-1:LEN_W], len});
		cfg_write(REG_BASE, {junk[CFG_DATA_W-1:ADDR_W], base});
		cfg_write(REG_SIZE, {junk[CFG_DATA_W-1:ADDR_W], size});
	endtask

	// new register setting per phase; the first phases walk through the extremes
	task automatic random_configure();
		pattern_t              pat;
		logic [PAT_BYTES-1:0]  care;
		logic [LEN_W-1:0]      len;
		logic [ADDR_W-1:0]     base;
		logic [ADDR_W-1:0]     size;
		int                    sel;
		int                    b;
		case ($urandom_range(5))
			0:       pat = '0;
			1:       pat = '1;
			default: for (b = 0; b < PAT_BYTES; b++) pat[b] = 8'($urandom);
		endcase
		sel = (phase_no < 4) ? phase_no : $urandom_range(4, 15);
		case (sel)
			0: begin
				len = LEN_W'(1); care = '0; base = '0; size = '1;
			end
			1: begin
				len = LEN_W'(24); care = '1; base = '1; size = '0;
			end
			2: begin
				// longer than the window: clipped to the full window
				len = LEN_W'(31); care = '1; base = 32'hFFFF_FFF8;
				size = $urandom_range(1, 40);
			end
			3: begin
				// zero length acts as one
				len = '0; care = PAT_BYTES'($urandom); base = $urandom;
				size = $urandom_range(1, 40);
			end
			default: begin
				len  = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(25, 31))
					: LEN_W'($urandom_range(1, 24));
				care = ($urandom_range(2) == 0) ? PAT_BYTES'($urandom | $urandom)
					: PAT_BYTES'($urandom);
				base = ($urandom_range(4) == 0) ? 32'hFFFF_FFF0 | 32'($urandom_range(15)) : $urandom;
				case ($urandom_range(9))
					0:       size = '0;
					1:       size = '1;
					default: size = $urandom_range(1, 40);
				endcase
			end
		endcase
		configure(pat, care, len, base, size, 1'($urandom_range(1)));
		phase_no++;
	endtask

	// one scan with random content; most are well formed, some planted with the pattern,
	// the rest cut short, run long, restarted, left open, sent with no first byte or followed by dropped bytes
	task automatic push_scan();
		logic [DATA_W-1:0] body [$];
		int                n;
		int                span;
		int                len;
		int                at;
		int                kind;
		int                restart_at;
		int                i;
		int                j;
		n    = pattern_span(scan_cfg.length);
		kind = $urandom_range(19);
		if (scan_cfg.size == 0) begin
			len = $urandom_range(1, 8);
		end else begin
			span = (scan_cfg.size > 40) ? 40 : int'(scan_cfg.size);
			len  = span + n - 1;
		end
		if (kind <= 1)
			len = $urandom_range(1, len);
		else if (kind == 2)
			len += $urandom_range(1, 6);
		// half the bytes come from the pattern so near misses are common
		for (i = 0; i < len; i++)
			body.push_back($urandom_range(1) ? scan_cfg.pattern[$urandom_range(n - 1)]
				: 8'($urandom));
		if ($urandom_range(1) && len >= n) begin
			at = $urandom_range(0, len - n);
			for (j = 0; j < n; j++)
				if (scan_cfg.care[j])
					body[at + j] = scan_cfg.pattern[j];
		end
		restart_at = (kind == 3 && len > 1) ? $urandom_range(1, len - 1) : 0;
		for (i = 0; i < len; i++)
			push_byte(body[i], (i == 0 && kind != 6) || (kind == 3 && i == restart_at),
				i == len - 1 && kind != 4);
		if (kind == 5)
			repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0, 1'($urandom_range(1)));
		// a scan with no first byte is not counted; after a finished one it is dropped whole
		if (kind != 6)
			random_bytes += len;
	endtask

	initial begin : stimulus
		pattern_t pat;
		queued_count   = 0;
		accepted_count = 0;
		mismatch_count = 0;
		random_bytes   = 0;
		phase_no       = 0;
		src_idle_pct   = 14;
		snk_idle_pct   = 46;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset setting: length one, no candidates, so a lone byte ends as not found
		push_byte(8'h00, 1'b1, 1'b1);
		wait_idle();
		cfg_write(REG_UNUSED, 64'h0123_4567_89AB_CDEF);

		// three bytes, middle one a wildcard, base at the top of the address space
		pat       = '0;
		pat[7:0]  = 64'hC3C3_C3C3_C300_5AFF;
		configure(pat, 24'hFFFFFD, LEN_W'(3), 32'hFFFF_FFFF, 32'd4, 1'b0);
		// match at offset zero, then a byte dropped after the result
		push_byte(8'hFF, 1'b1, 1'b0);
		push_byte(8'h12, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'h55, 1'b0, 1'b1);
		// match at offset one: address wraps to zero
		push_byte(8'h00, 1'b1, 1'b0);
		push_byte(8'hFF, 1'b0, 1'b0);
		push_byte(8'h34, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);
		// stream ends before all candidates were tried
		push_byte(8'h01, 1'b1, 1'b0);
		push_byte(8'h02, 1'b0, 1'b0);
		push_byte(8'h03, 1'b0, 1'b1);
		// match completed by the last byte: found only
		push_byte(8'h00, 1'b1, 1'b0);
		push_byte(8'hFF, 1'b0, 1'b0);
		push_byte(8'h77, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0, 1'b1);
		// single byte scan, shorter than the pattern
		push_byte(8'hFF, 1'b1, 1'b1);
		wait_idle();

		// zero length behaves as one byte
		pat    = '0;
		pat[0] = 8'hAB;
		configure(pat, '1, '0, 32'd100, 32'd2, 1'b1);
		push_byte(8'h00, 1'b1, 1'b0);
		push_byte(8'hAB, 1'b0, 1'b1);
		wait_idle();

		// random phases; the stream stops between phases until every result is back
		while (random_bytes < 1500) begin
			if (random_bytes < 500) begin
				src_idle_pct = 14;
				snk_idle_pct = 46;
			end else if (random_bytes < 1000) begin
				src_idle_pct = 46;
				snk_idle_pct = 14;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			random_configure();
			repeat ($urandom_range(2, 4)) push_scan();
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("masked_byte_pattern_scan: match");
		else
			$display("masked_byte_pattern_scan: mismatch");
		$finish;
	end

endmodule
